@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the Givens rotation block.
// Every macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at each rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    `ASSERT_AT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/gvr_pkg.sv @@
// Shared types and helper functions for the Givens rotation block.
// Has no dependencies. The square root cell and the top level use it.
package gvr_pkg;

    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic zero;
    } gvr_flags_t;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

@@ rtl/gvr_div_cell.sv @@
// One restoring-division cell: produces one quotient bit for the cosine
// lane and one for the sine lane, over a shared divisor. No dependencies.
module gvr_div_cell #(
    parameter int SW    = 64,
    parameter int QW    = 63,
    parameter bit FIRST = 1'b0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [SW-1:0] den_i,
    input  logic [SW-1:0] rem_c_i,
    input  logic [SW-1:0] rem_s_i,
    input  logic [QW-1:0] quo_c_i,
    input  logic [QW-1:0] quo_s_i,
    output logic [SW-1:0] den_o,
    output logic [SW-1:0] rem_c_o,
    output logic [SW-1:0] rem_s_o,
    output logic [QW-1:0] quo_c_o,
    output logic [QW-1:0] quo_s_o
);

    logic [SW:0]   tc, ts, dw;
    logic          gc, gs;
    logic [SW-1:0] den_reg, rem_c_reg, rem_s_reg;
    logic [SW-1:0] rem_c_next, rem_s_next;
    logic [QW-1:0] quo_c_reg, quo_s_reg, quo_c_next, quo_s_next;

    always_comb begin
        dw = {1'b0, den_i};
        tc = FIRST ? {1'b0, rem_c_i} : {rem_c_i, 1'b0};
        ts = FIRST ? {1'b0, rem_s_i} : {rem_s_i, 1'b0};
        gc = (tc >= dw);
        gs = (ts >= dw);
        rem_c_next = gc ? SW'(tc - dw) : tc[SW-1:0];
        rem_s_next = gs ? SW'(ts - dw) : ts[SW-1:0];
        quo_c_next = {quo_c_i[QW-2:0], gc};
        quo_s_next = {quo_s_i[QW-2:0], gs};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= den_i;
            rem_c_reg <= rem_c_next;
            rem_s_reg <= rem_s_next;
            quo_c_reg <= quo_c_next;
            quo_s_reg <= quo_s_next;
        end
    end

    assign den_o   = den_reg;
    assign rem_c_o = rem_c_reg;
    assign rem_s_o = rem_s_reg;
    assign quo_c_o = quo_c_reg;
    assign quo_s_o = quo_s_reg;

endmodule

@@ rtl/gvr_sqrt_cell.sv @@
// One digit-by-digit square root cell: decides root bit BIT.
// Depends on gvr_pkg.
module gvr_sqrt_cell #(
    parameter int XW  = 63,
    parameter int RW  = 32,
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [XW-1:0] x_i,
    input  logic [RW-1:0] root_i,
    output logic [XW-1:0] x_o,
    output logic [RW-1:0] root_o
);

    localparam int TW = gvr_pkg::imax(XW, 2 * RW) + 1;

    logic [TW-1:0] rem_w, delta;
    logic          ge;
    logic [XW-1:0] x_reg, x_next;
    logic [RW-1:0] root_reg, root_next;

    always_comb begin
        rem_w = TW'(x_i);
        delta = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        ge = (rem_w >= delta);
        x_next = ge ? XW'(rem_w - delta) : x_i;
        root_next = root_i;
        root_next[BIT] = ge;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            root_reg <= root_next;
        end
    end

    assign x_o    = x_reg;
    assign root_o = root_reg;

endmodule

@@ rtl/givens_rotation_coefficients.sv @@
// Top level of the Givens rotation coefficient block.
// Depends on gvr_pkg, gvr_div_cell, gvr_sqrt_cell and assert_macros.svh.
//
// The slave channel takes one pair (elem_a, elem_b) per transfer. The master
// channel returns one transfer per pair with c, s and r = hypot(a, b), where
// the rotation [[c, -s], [s, c]] maps (a, b) to (r, 0). The coefficients are
// Q1.COEF_FRAC_BITS, and r is rounded to the nearest integer.
// When both inputs are zero, tuser flags it and all data fields are zero.
// The block accepts one pair every cycle while the receiver does not stall.
// Registers square and sum the inputs, one division cell per quotient bit
// and one root cell per root bit follow, and then the output register.
// The radius root runs beside the division cells; whichever of the two
// paths is shorter is delayed so that they line up.
// Reset clears every valid bit, so no transfer is pending afterwards.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_tready drops in the same cycle; it rises again when the result is taken.
module givens_rotation_coefficients #(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // elem_a, elem_b
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // cos_value, sin_value, radius
    output logic [((2*(COEF_FRAC_BITS+2)+DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // both_zero
    output logic m_tuser
);

    `include "assert_macros.svh"

    localparam int DW   = DATA_WIDTH;
    localparam int F    = COEF_FRAC_BITS;
    localparam int CW   = F + 2;
    localparam int SW   = 2 * DW;
    localparam int QW   = 2 * F + 3;
    localparam int CRW  = F + 2;
    localparam int RRW  = DW + 1;
    localparam int RXW  = SW + 2;
    localparam int LH   = DW / 2;
    localparam int HH   = DW - LH;
    localparam int LCS  = QW + CRW;
    localparam int LMID = gvr_pkg::imax(LCS, RRW);
    localparam int CPAD = LMID - LCS;
    localparam int RPAD = LMID - RRW;
    localparam int NV   = 4 + LMID;
    localparam int ODW  = ((2 * CW + DW + 7) / 8) * 8;
    localparam logic [CW-1:0] COEF_ONE = CW'(1) << F;

    logic en;
    logic [DW-1:0] a_in, b_in;
    gvr_pkg::gvr_flags_t fl_in;

    logic                vld_reg [0:NV-1];
    gvr_pkg::gvr_flags_t fl_reg  [0:NV-1];

    logic [DW-1:0]      amag_reg, bmag_reg;
    logic [2*HH-1:0]    ahh_reg, bhh_reg;
    logic [HH+LH-1:0]   ahl_reg, bhl_reg;
    logic [2*LH-1:0]    all_reg, bll_reg;
    logic [SW-1:0]      a2_reg, b2_reg, a2d_reg, b2d_reg, sum_reg;

    logic [SW-1:0] den [0:QW];
    logic [SW-1:0] rc  [0:QW];
    logic [SW-1:0] rs  [0:QW];
    logic [QW-1:0] qc  [0:QW];
    logic [QW-1:0] qs  [0:QW];

    logic [QW-1:0]  cx [0:CRW];
    logic [QW-1:0]  sx [0:CRW];
    logic [CRW-1:0] cr [0:CRW];
    logic [CRW-1:0] sr [0:CRW];
    logic [RXW-1:0] rx [0:RRW];
    logic [RRW-1:0] rr [0:RRW];

    logic [CRW-1:0] croot_fin, sroot_fin;
    logic [RRW-1:0] rroot_fin;

    logic [CRW:0]   csum, ssum;
    logic [RRW:0]   rsum;
    logic [CW-1:0]  c_mag, s_mag, cos_next, sin_next, cos_reg, sin_reg;
    logic [DW-1:0]  radius_next, radius_reg;
    logic           m_valid_reg, zero_reg;
    gvr_pkg::gvr_flags_t fl_out;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign a_in        = s_tdata[DW-1:0];
    assign b_in        = s_tdata[2*DW-1:DW];
    assign fl_in.a_neg = a_in[DW-1];
    assign fl_in.b_neg = b_in[DW-1];
    assign fl_in.zero  = (a_in == '0) && (b_in == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NV; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl_reg[0] <= fl_in;
            for (int i = 1; i < NV; i++) begin
                fl_reg[i] <= fl_reg[i-1];
            end
            amag_reg <= a_in[DW-1] ? (~a_in + DW'(1)) : a_in;
            bmag_reg <= b_in[DW-1] ? (~b_in + DW'(1)) : b_in;
            ahh_reg  <= {HH'(0), amag_reg[DW-1:LH]} * {HH'(0), amag_reg[DW-1:LH]};
            bhh_reg  <= {HH'(0), bmag_reg[DW-1:LH]} * {HH'(0), bmag_reg[DW-1:LH]};
            ahl_reg  <= {LH'(0), amag_reg[DW-1:LH]} * {HH'(0), amag_reg[LH-1:0]};
            bhl_reg  <= {LH'(0), bmag_reg[DW-1:LH]} * {HH'(0), bmag_reg[LH-1:0]};
            all_reg  <= {LH'(0), amag_reg[LH-1:0]} * {LH'(0), amag_reg[LH-1:0]};
            bll_reg  <= {LH'(0), bmag_reg[LH-1:0]} * {LH'(0), bmag_reg[LH-1:0]};
            a2_reg   <= (SW'(ahh_reg) << (2 * LH)) + (SW'(ahl_reg) << (LH + 1))
                        + SW'(all_reg);
            b2_reg   <= (SW'(bhh_reg) << (2 * LH)) + (SW'(bhl_reg) << (LH + 1))
                        + SW'(bll_reg);
            sum_reg  <= a2_reg + b2_reg;
            a2d_reg  <= a2_reg;
            b2d_reg  <= b2_reg;
        end
    end

    assign den[0] = sum_reg;
    assign rc[0]  = a2d_reg;
    assign rs[0]  = b2d_reg;
    assign qc[0]  = '0;
    assign qs[0]  = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        gvr_div_cell #(
            .SW    (SW),
            .QW    (QW),
            .FIRST (k == 0)
        ) u_cell (
            .aclk    (aclk),
            .en      (en),
            .den_i   (den[k]),
            .rem_c_i (rc[k]),
            .rem_s_i (rs[k]),
            .quo_c_i (qc[k]),
            .quo_s_i (qs[k]),
            .den_o   (den[k+1]),
            .rem_c_o (rc[k+1]),
            .rem_s_o (rs[k+1]),
            .quo_c_o (qc[k+1]),
            .quo_s_o (qs[k+1])
        );
    end

    assign cx[0] = qc[QW];
    assign sx[0] = qs[QW];
    assign cr[0] = '0;
    assign sr[0] = '0;

    for (genvar j = 0; j < CRW; j++) begin : g_csqrt
        gvr_sqrt_cell #(
            .XW  (QW),
            .RW  (CRW),
            .BIT (CRW - 1 - j)
        ) u_cos (
            .aclk   (aclk),
            .en     (en),
            .x_i    (cx[j]),
            .root_i (cr[j]),
            .x_o    (cx[j+1]),
            .root_o (cr[j+1])
        );
        gvr_sqrt_cell #(
            .XW  (QW),
            .RW  (CRW),
            .BIT (CRW - 1 - j)
        ) u_sin (
            .aclk   (aclk),
            .en     (en),
            .x_i    (sx[j]),
            .root_i (sr[j]),
            .x_o    (sx[j+1]),
            .root_o (sr[j+1])
        );
    end

    assign rx[0] = {sum_reg, 2'b00};
    assign rr[0] = '0;

    for (genvar j = 0; j < RRW; j++) begin : g_rsqrt
        gvr_sqrt_cell #(
            .XW  (RXW),
            .RW  (RRW),
            .BIT (RRW - 1 - j)
        ) u_cell (
            .aclk   (aclk),
            .en     (en),
            .x_i    (rx[j]),
            .root_i (rr[j]),
            .x_o    (rx[j+1]),
            .root_o (rr[j+1])
        );
    end

    if (CPAD > 0) begin : g_cpad
        logic [CRW-1:0] cdly_reg [1:CPAD];
        logic [CRW-1:0] sdly_reg [1:CPAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                cdly_reg[1] <= cr[CRW];
                sdly_reg[1] <= sr[CRW];
                for (int i = 2; i <= CPAD; i++) begin
                    cdly_reg[i] <= cdly_reg[i-1];
                    sdly_reg[i] <= sdly_reg[i-1];
                end
            end
        end
        assign croot_fin = cdly_reg[CPAD];
        assign sroot_fin = sdly_reg[CPAD];
    end else begin : g_cnopad
        assign croot_fin = cr[CRW];
        assign sroot_fin = sr[CRW];
    end

    if (RPAD > 0) begin : g_rpad
        logic [RRW-1:0] rdly_reg [1:RPAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                rdly_reg[1] <= rr[RRW];
                for (int i = 2; i <= RPAD; i++) begin
                    rdly_reg[i] <= rdly_reg[i-1];
                end
            end
        end
        assign rroot_fin = rdly_reg[RPAD];
    end else begin : g_rnopad
        assign rroot_fin = rr[RRW];
    end

    always_comb begin
        fl_out      = fl_reg[NV-1];
        csum        = {1'b0, croot_fin} + (CRW + 1)'(1);
        ssum        = {1'b0, sroot_fin} + (CRW + 1)'(1);
        rsum        = {1'b0, rroot_fin} + (RRW + 1)'(1);
        c_mag       = csum[CRW:1];
        s_mag       = ssum[CRW:1];
        cos_next    = fl_out.a_neg ? (~c_mag + CW'(1)) : c_mag;
        sin_next    = fl_out.b_neg ? s_mag : (~s_mag + CW'(1));
        radius_next = rsum[DW:1];
        if (fl_out.zero) begin
            cos_next    = '0;
            sin_next    = '0;
            radius_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[NV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg    <= cos_next;
            sin_reg    <= sin_next;
            radius_reg <= radius_next;
            zero_reg   <= fl_out.zero;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ODW'({radius_reg, sin_reg, cos_reg});
    assign m_tuser  = zero_reg;

    `ASSERT_IMPLY(a_zero_clears, m_valid_reg && zero_reg,
        cos_reg == '0 && sin_reg == '0 && radius_reg == '0,
        "Zero input pair gave a nonzero result.")
    `ASSERT_IMPLY(a_radius_nonzero, m_valid_reg && !zero_reg,
        radius_reg != '0,
        "Nonzero input pair gave a zero radius.")
    `ASSERT_IMPLY(a_cos_range, m_valid_reg,
        $signed(cos_reg) <= $signed(COEF_ONE) && $signed(cos_reg) >= -$signed(COEF_ONE),
        "Cosine is outside the range of plus or minus one.")
    `ASSERT_IMPLY(a_sin_range, m_valid_reg,
        $signed(sin_reg) <= $signed(COEF_ONE) && $signed(sin_reg) >= -$signed(COEF_ONE),
        "Sine is outside the range of plus or minus one.")

endmodule
